// File: hdl/eink_pixel_tone_curve_top_macros.svh
// ----------------------------------------------------------------------------
// Tone curve assertion macros
// Shared concurrent assertion forms for the pixel tone curve block.
// ----------------------------------------------------------------------------
`ifndef EINK_PIXEL_TONE_CURVE_TOP_MACROS_SVH
`define EINK_PIXEL_TONE_CURVE_TOP_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define EPT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// The consequent must hold after the delay dly, counted from the antecedent.
`define EPT_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##(dly) (cons)) \
      else $error(msg);

`endif

// File: hdl/ept_pkg.sv
// ----------------------------------------------------------------------------
// Tone curve package
// Types, register codes and shared arithmetic helpers for the tone curve.
// ----------------------------------------------------------------------------
package ept_pkg;

   // Register selects, decoded from paddr bit 2.
   localparam logic EPT_REG_VARIANT = 1'b0;
   localparam logic EPT_REG_QUALITY = 1'b1;

   // Register stages from an accepted pixel to its result strobe.
   localparam int EPT_LATENCY = 7;

   // Reciprocal of 100 scaled by 2**19; exact for magnitudes below 43690.
   localparam logic [12:0] EPT_RECIP100 = 13'd5243;
   // Reciprocal of 3 scaled by 2**9; exact for small operands.
   localparam logic [8:0]  EPT_RECIP3   = 9'd171;

   typedef struct packed {
      logic variant;
      logic quality;
   } ept_cfg_type;

   // Handoff from the sharpening half to the shaping half of the pipeline.
   typedef struct packed {
      logic              valid;
      logic [7:0]        gray;
      logic [7:0]        sharp;
      logic              alt_en;
      logic [7:0]        alt_tone;
      logic signed [6:0] knee;
      logic signed [4:0] dith;
   } ept_mid_type;

   // Signed division by 100 truncating toward zero.
   function automatic logic signed [9:0] ept_div100(input logic signed [16:0] v);
      logic [15:0] mag;
      logic [28:0] prod;
      logic [9:0]  quo;
      mag  = v[16] ? 16'(-v) : 16'(v);
      prod = 29'(mag) * 29'(EPT_RECIP100);
      quo  = prod[28:19];
      if (v[16]) begin
         return -$signed(quo);
      end
      return $signed(quo);
   endfunction

   function automatic logic [7:0] ept_clamp8(input logic signed [10:0] v);
      if (v < 11'sd0) begin
         return 8'd0;
      end
      if (v > 11'sd255) begin
         return 8'd255;
      end
      return v[7:0];
   endfunction

endpackage

// File: hdl/ept_front.sv
// ----------------------------------------------------------------------------
// Tone curve front stages
// Neighbor difference, lift, knee and dither terms, and the sharpened gray.
// ----------------------------------------------------------------------------
module ept_front (
   input  logic                clock,
   input  logic                reset,
   input  ept_pkg::ept_cfg_type cfg,
   input  logic                in_valid,
   input  logic [7:0]          center_gray,
   input  logic [7:0]          left_gray,
   input  logic [7:0]          right_gray,
   input  logic [11:0]         pixel_x,
   input  logic [11:0]         pixel_y,
   output ept_pkg::ept_mid_type mid
);
   import ept_pkg::*;

   // Stage 1 signals.
   logic [8:0]         pair_sum;
   logic [7:0]         nb_avg;
   logic [5:0]         lift;
   logic [8:0]         alt_sum;
   logic [6:0]         knee_d;
   logic [3:0]         lat_a;
   logic [2:0]         lat_b;

   logic               s1_valid_ff, s1_valid_in;
   logic [7:0]         s1_gray_ff, s1_gray_in;
   logic signed [9:0]  s1_det_ff, s1_det_in;
   logic [7:0]         s1_altg_ff, s1_altg_in;
   logic [12:0]        s1_knee_p_ff, s1_knee_p_in;
   logic signed [5:0]  s1_dith_s_ff, s1_dith_s_in;

   // Stage 2 signals.
   logic [6:0]         gain;
   logic [16:0]        knee_prod;
   logic [5:0]         knee_q;
   logic [5:0]         dith_mag;
   logic [12:0]        dith_prod;
   logic [3:0]         dith_q;

   logic               s2_valid_ff, s2_valid_in;
   logic [7:0]         s2_gray_ff, s2_gray_in;
   logic signed [9:0]  s2_det_ff, s2_det_in;
   logic signed [16:0] s2_bp_ff, s2_bp_in;
   logic signed [16:0] s2_ap_ff, s2_ap_in;
   logic signed [6:0]  s2_knee_ff, s2_knee_in;
   logic signed [4:0]  s2_dith_ff, s2_dith_in;

   // Stage 3 signals.
   logic signed [9:0]  boost_raw;
   logic signed [9:0]  boost_lim;
   logic signed [9:0]  boost;
   logic signed [9:0]  sharp_thr;
   logic               sharp_on;

   ept_mid_type        s3_ff, s3_in;

   // ---------------------------------------------------------------- stage 1
   always_comb begin
      pair_sum = {1'b0, left_gray} + {1'b0, right_gray};
      nb_avg   = pair_sum[8:1];
      s1_det_in = $signed({2'b00, center_gray}) - $signed({2'b00, nb_avg});

      // Highlight edge lift saturates at 50 once the difference passes 21.
      if (s1_det_in > 10'sd21) begin
         lift = 6'd50;
      end else if (s1_det_in > 10'sd5) begin
         lift = 6'((s1_det_in - 10'sd5) * 10'sd3);
      end else begin
         lift = 6'd0;
      end
      alt_sum    = {1'b0, center_gray} + {3'b000, lift};
      s1_altg_in = alt_sum[8] ? 8'hFF : alt_sum[7:0];

      // Knee distance is only used when the gray is below 96.
      knee_d       = 7'(8'd96 - center_gray);
      s1_knee_p_in = cfg.variant ? 13'(knee_d) * 13'd56 : 13'(knee_d) * 13'd6;

      // The lattice terms only depend on the low coordinate bits.
      lat_a = (pixel_x[3:0] * 4'd13) + (pixel_y[3:0] * 4'd7)
            + ((pixel_x[3:0] ^ pixel_y[3:0]) * 4'd3);
      lat_b = (pixel_x[2:0] + pixel_y[2:0] * 3'd3) * 3'd5;
      s1_dith_s_in = $signed({2'b00, lat_a}) + $signed({3'b000, lat_b}) - 6'sd12;

      s1_valid_in = in_valid;
      s1_gray_in  = center_gray;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_gray_ff   <= s1_gray_in;
      s1_det_ff    <= s1_det_in;
      s1_altg_ff   <= s1_altg_in;
      s1_knee_p_ff <= s1_knee_p_in;
      s1_dith_s_ff <= s1_dith_s_in;
   end

   // ---------------------------------------------------------------- stage 2
   always_comb begin
      gain     = cfg.quality ? 7'd105 : 7'd80;
      s2_bp_in = 17'(s1_det_ff) * $signed({10'b0, gain});
      s2_ap_in = 17'($signed({1'b0, s1_altg_ff}) - 9'sd128) <<< 7;

      // Knee: (distance * lift) / 96, done as a shift by 32 and a divide by 3.
      knee_prod  = 17'(s1_knee_p_ff[12:5]) * 17'(EPT_RECIP3);
      knee_q     = knee_prod[14:9];
      s2_knee_in = cfg.variant ? $signed({1'b0, knee_q}) : -$signed({1'b0, knee_q});

      // Dither: (sum * 8) / 12 equals two thirds of the sum, toward zero.
      dith_mag   = s1_dith_s_ff[5] ? 6'(-s1_dith_s_ff) : 6'(s1_dith_s_ff);
      dith_prod  = 13'({dith_mag[3:0], 1'b0}) * 13'(EPT_RECIP3);
      dith_q     = dith_prod[12:9];
      s2_dith_in = s1_dith_s_ff[5] ? -$signed({1'b0, dith_q}) : $signed({1'b0, dith_q});

      s2_valid_in = s1_valid_ff;
      s2_gray_in  = s1_gray_ff;
      s2_det_in   = s1_det_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_gray_ff <= s2_gray_in;
      s2_det_ff  <= s2_det_in;
      s2_bp_ff   <= s2_bp_in;
      s2_ap_ff   <= s2_ap_in;
      s2_knee_ff <= s2_knee_in;
      s2_dith_ff <= s2_dith_in;
   end

   // ---------------------------------------------------------------- stage 3
   always_comb begin
      boost_raw = ept_div100(s2_bp_ff);
      boost_lim = cfg.quality ? 10'sd38 : 10'sd130;
      sharp_thr = cfg.quality ? 10'sd3 : 10'sd18;
      if (boost_raw > boost_lim) begin
         boost = boost_lim;
      end else if (boost_raw < -boost_lim) begin
         boost = -boost_lim;
      end else begin
         boost = boost_raw;
      end
      sharp_on = (s2_det_ff > sharp_thr) || (s2_det_ff < -sharp_thr);

      s3_in.valid    = s2_valid_ff;
      s3_in.gray     = s2_gray_ff;
      s3_in.sharp    = sharp_on ? ept_clamp8($signed({3'b000, s2_gray_ff}) + 11'(boost))
                                : s2_gray_ff;
      s3_in.alt_en   = s2_det_ff > 10'sd5;
      s3_in.alt_tone = ept_clamp8(11'(ept_div100(s2_ap_ff)) + 11'sd128);
      s3_in.knee     = s2_knee_ff;
      s3_in.dith     = s2_dith_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff <= '0;
      end else begin
         s3_ff <= s3_in;
      end
   end

   assign mid = s3_ff;

endmodule

// File: hdl/ept_back.sv
// ----------------------------------------------------------------------------
// Tone curve back stages
// Contrast curves, band lifts, knee, end snaps, dither and panel stretch.
// ----------------------------------------------------------------------------
module ept_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ept_pkg::ept_cfg_type  cfg,
   input  ept_pkg::ept_mid_type  mid,
   output logic                 out_valid,
   output logic [7:0]           out_tone
);
   import ept_pkg::*;

   // Stage 4 signals.
   logic signed [8:0]  sharp_off;

   logic               s4_valid_ff, s4_valid_in;
   logic [7:0]         s4_gray_ff, s4_gray_in;
   logic signed [16:0] s4_cp_ff, s4_cp_in;
   logic               s4_bias_hi_ff, s4_bias_hi_in;
   logic               s4_alt_en_ff, s4_alt_en_in;
   logic [7:0]         s4_alt_tone_ff, s4_alt_tone_in;
   logic signed [6:0]  s4_knee_ff, s4_knee_in;
   logic signed [4:0]  s4_dith_ff, s4_dith_in;

   // Stage 5 signals.
   logic signed [10:0] curve_t;
   logic [7:0]         med_t;
   logic signed [10:0] qual_t;

   logic               s5_valid_ff, s5_valid_in;
   logic [7:0]         s5_gray_ff, s5_gray_in;
   logic signed [10:0] s5_tone_ff, s5_tone_in;
   logic signed [4:0]  s5_dith_ff, s5_dith_in;

   // Stage 6 signals.
   logic signed [10:0] dith_add;

   logic               s6_valid_ff, s6_valid_in;
   logic [7:0]         s6_res_ff, s6_res_in;
   logic signed [16:0] s6_vp_ff, s6_vp_in;
   logic               s6_use_vp_ff, s6_use_vp_in;
   logic               s6_low_ff, s6_low_in;
   logic               s6_high_ff, s6_high_in;

   // Output stage.
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_tone_ff, out_tone_in;

   // ---------------------------------------------------------------- stage 4
   always_comb begin
      if (!cfg.quality) begin
         sharp_off = $signed({1'b0, mid.sharp}) - 9'sd128;
         s4_cp_in  = 17'(sharp_off) <<< 7;
      end else if (mid.sharp[7]) begin
         sharp_off = $signed({1'b0, mid.sharp}) - 9'sd128;
         s4_cp_in  = 17'(sharp_off) * 17'sd162;
      end else begin
         sharp_off = $signed({1'b0, mid.sharp}) - 9'sd64;
         s4_cp_in  = 17'(sharp_off) * 17'sd122;
      end
      // The split curve pivots at 64 below mid gray, everything else at 128.
      s4_bias_hi_in  = mid.sharp[7] || !cfg.quality;
      s4_valid_in    = mid.valid;
      s4_gray_in     = mid.gray;
      s4_alt_en_in   = mid.alt_en;
      s4_alt_tone_in = mid.alt_tone;
      s4_knee_in     = mid.knee;
      s4_dith_in     = mid.dith;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s4_gray_ff     <= s4_gray_in;
      s4_cp_ff       <= s4_cp_in;
      s4_bias_hi_ff  <= s4_bias_hi_in;
      s4_alt_en_ff   <= s4_alt_en_in;
      s4_alt_tone_ff <= s4_alt_tone_in;
      s4_knee_ff     <= s4_knee_in;
      s4_dith_ff     <= s4_dith_in;
   end

   // ---------------------------------------------------------------- stage 5
   always_comb begin
      curve_t = 11'(ept_div100(s4_cp_ff)) + (s4_bias_hi_ff ? 11'sd128 : 11'sd64);

      med_t = ept_clamp8(curve_t);
      if (s4_alt_en_ff && (s4_alt_tone_ff > med_t)) begin
         med_t = s4_alt_tone_ff;
      end
      if ((s4_gray_ff >= 8'd52) && (s4_gray_ff <= 8'd126)) begin
         med_t = ept_clamp8($signed({3'b000, med_t}) + 11'sd6);
      end
      if ((s4_gray_ff >= 8'd104) && (s4_gray_ff <= 8'd188)) begin
         med_t = ept_clamp8($signed({3'b000, med_t}) + 11'sd8);
      end

      qual_t = curve_t + ((s4_gray_ff < 8'd96) ? 11'(s4_knee_ff) : 11'sd0);

      s5_tone_in  = cfg.quality ? qual_t : $signed({3'b000, med_t});
      s5_valid_in = s4_valid_ff;
      s5_gray_in  = s4_gray_ff;
      s5_dith_in  = s4_dith_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s5_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s5_gray_ff <= s5_gray_in;
      s5_tone_ff <= s5_tone_in;
      s5_dith_ff <= s5_dith_in;
   end

   // ---------------------------------------------------------------- stage 6
   always_comb begin
      dith_add = ((s5_gray_ff > 8'd22) && (s5_gray_ff < 8'd208)) ? 11'(s5_dith_ff)
                                                                 : 11'sd0;
      if (cfg.quality) begin
         // Solid gray ends win over everything shaped after them.
         if (s5_gray_ff <= 8'd12) begin
            s6_res_in = 8'd0;
         end else if (s5_gray_ff >= 8'd218) begin
            s6_res_in = 8'd255;
         end else if (s5_tone_ff <= 11'sd8) begin
            s6_res_in = 8'd0;
         end else if (s5_tone_ff >= 11'sd238) begin
            s6_res_in = 8'd255;
         end else begin
            s6_res_in = ept_clamp8(s5_tone_ff + dith_add);
         end
      end else begin
         s6_res_in = s5_tone_ff[7:0];
      end

      s6_vp_in     = 17'(s5_tone_ff - 11'sd180) * 17'sd120;
      s6_use_vp_in = cfg.variant && !cfg.quality;
      s6_low_in    = s5_tone_ff <= 11'sd20;
      s6_high_in   = s5_tone_ff >= 11'sd255;
      s6_valid_in  = s5_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s6_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s6_res_ff    <= s6_res_in;
      s6_vp_ff     <= s6_vp_in;
      s6_use_vp_ff <= s6_use_vp_in;
      s6_low_ff    <= s6_low_in;
      s6_high_ff   <= s6_high_in;
   end

   // ----------------------------------------------------------- output stage
   always_comb begin
      if (!s6_use_vp_ff) begin
         out_tone_in = s6_res_ff;
      end else if (s6_low_ff) begin
         out_tone_in = 8'd0;
      end else if (s6_high_ff) begin
         out_tone_in = 8'd255;
      end else begin
         out_tone_in = ept_clamp8(11'(ept_div100(s6_vp_ff)) + 11'sd180);
      end
      out_valid_in = s6_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_tone_ff <= out_tone_in;
   end

   assign out_valid = out_valid_ff;
   assign out_tone  = out_tone_ff;

endmodule

// File: hdl/eink_pixel_tone_curve_top.sv
// ----------------------------------------------------------------------------
// E-paper pixel tone curve
// Shapes one gray pixel per clock into a panel tone from its neighbors.
// ----------------------------------------------------------------------------
//  Channel   Handshake                        Payload
//  request   start (busy is always low)       req_center/left/right_gray, req_pixel_x/y
//  response  rsp_valid, one-cycle strobe      rsp_tone
//  config    psel/penable/pwrite, pready = 1  paddr, pwdata, prdata
//
//  A pixel is accepted at every edge where start is high; one can enter each cycle.
//  Its tone appears on rsp_tone with rsp_valid after the seven register stages of
//  the curve pipeline, one per pixel, in order.
//  Reset clears the stage valid bits and both configuration registers.
//  The result port cannot be stalled, so the pipeline never holds.
// ----------------------------------------------------------------------------
`include "eink_pixel_tone_curve_top_macros.svh"

module eink_pixel_tone_curve_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_center_gray,
   input  logic [7:0]  req_left_gray,
   input  logic [7:0]  req_right_gray,
   input  logic [11:0] req_pixel_x,
   input  logic [11:0] req_pixel_y,
   output logic        rsp_valid,
   output logic [7:0]  rsp_tone,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import ept_pkg::*;

   logic        panel_variant_ff, panel_variant_in;
   logic        quality_curve_ff, quality_curve_in;
   logic        csr_write;
   ept_cfg_type cfg;
   ept_mid_type mid;

   // ------------------------------------------------------------ config port
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      panel_variant_in = panel_variant_ff;
      quality_curve_in = quality_curve_ff;
      if (csr_write) begin
         case (paddr[2])
            EPT_REG_VARIANT: panel_variant_in = pwdata[0];
            EPT_REG_QUALITY: quality_curve_in = pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_variant_ff <= 1'b0;
         quality_curve_ff <= 1'b0;
      end else begin
         panel_variant_ff <= panel_variant_in;
         quality_curve_ff <= quality_curve_in;
      end
   end

   always_comb begin
      case (paddr[2])
         EPT_REG_VARIANT: prdata = {31'b0, panel_variant_ff};
         EPT_REG_QUALITY: prdata = {31'b0, quality_curve_ff};
         default:         prdata = 32'b0;
      endcase
   end

   assign pready      = 1'b1;
   assign cfg.variant = panel_variant_ff;
   assign cfg.quality = quality_curve_ff;

   // Fully pipelined with no back-pressure, so a transfer is never refused.
   assign busy = 1'b0;

   // -------------------------------------------------------------- pipeline
   ept_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (start && !busy),
      .center_gray (req_center_gray),
      .left_gray   (req_left_gray),
      .right_gray  (req_right_gray),
      .pixel_x     (req_pixel_x),
      .pixel_y     (req_pixel_y),
      .mid         (mid)
   );

   ept_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .mid       (mid),
      .out_valid (rsp_valid),
      .out_tone  (rsp_tone)
   );

   // ------------------------------------------------------------ assertions
   `EPT_ASSERT_DELAY(a_latency, start && !busy, EPT_LATENCY, rsp_valid, "missing tone strobe")
   `EPT_ASSERT_NEXT(a_variant_wr, csr_write && !paddr[2], panel_variant_ff == $past(pwdata[0]), "panel variant write lost")
   `EPT_ASSERT_NEXT(a_quality_wr, csr_write && paddr[2], quality_curve_ff == $past(pwdata[0]), "quality curve write lost")

endmodule
